[design/spq_pkg.sv]
// Package for the sorted priority queue: entry type, cell control
// bundle and status codes. No dependencies.
`default_nettype none

package spq_pkg;

  localparam int unsigned SPQ_DEPTH = 8;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned PRIO_W    = 16;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 56;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } spq_op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_e;

  typedef struct packed {
    logic signed [VAL_W-1:0]  value;
    logic signed [PRIO_W-1:0] prio;
  } spq_entry_t;

  typedef struct packed {
    logic       ins;
    logic       rem;
    spq_entry_t ent;
  } spq_ctrl_t;

endpackage

`default_nettype wire

[design/spq_cell.sv]
// One slot of the sorted chain: holds an entry and its valid bit,
// shifts back on insert and forward on remove. Uses spq_pkg.
`default_nettype none

module spq_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire spq_pkg::spq_ctrl_t  ctrl_i,
  input  wire spq_pkg::spq_entry_t left_ent_i,
  input  wire logic               left_valid_i,
  input  wire logic               left_keep_i,
  input  wire spq_pkg::spq_entry_t right_ent_i,
  input  wire logic               right_valid_i,
  output spq_pkg::spq_entry_t     ent_o,
  output logic                    valid_o,
  output logic                    keep_o
);
  import spq_pkg::*;

  spq_entry_t ent_q, ent_d;
  logic       valid_q, valid_d;

  // entry stays put on insert when it ranks at or above the new one
  assign keep_o  = valid_q && (ent_q.prio >= ctrl_i.ent.prio);
  assign ent_o   = ent_q;
  assign valid_o = valid_q;

  always_comb begin
    ent_d   = ent_q;
    valid_d = valid_q;
    if (ctrl_i.ins) begin
      if (!keep_o) begin
        ent_d = left_keep_i ? ctrl_i.ent : left_ent_i;
      end
      valid_d = valid_q | left_valid_i;
    end else if (ctrl_i.rem) begin
      ent_d   = right_ent_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

`default_nettype wire

[design/sorted_priority_queue_core.sv]
// Top level of the sorted priority queue: stream ports, occupancy count,
// output register and the chain of spq_cell slots. Uses spq_pkg.
//
//  channel | dir | handshake               | payload
//  s_axis  | in  | s_axis_tvalid/tready    | tdata: op, item_value, item_priority
//  m_axis  | out | m_axis_tvalid/tready    | tdata: status, removed_value,
//          |     |                         |        removed_priority, entry_count
//
// Each request is applied to all cells at once in the cycle it is accepted;
// the result is registered and shown the next cycle, so one request per cycle.
// A new request is taken while the held result leaves in the same cycle.
// Reset clears the valid bits and the count; entries need no clearing.
// A stalled output holds the result and blocks further requests.
`default_nettype none

module sorted_priority_queue_core #(
  parameter int unsigned DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [0] op, [32:1] item_value, [48:33] item_priority, [55:49] zero
  input  wire logic [spq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [1:0] status, [33:2] removed_value, [49:34] removed_priority,
  // [53:50] entry_count, [55:54] zero
  output logic [spq_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
  import spq_pkg::*;

  localparam int unsigned OCC_W = $clog2(DEPTH + 1);

  logic             in_fire;
  spq_op_e          op;
  spq_entry_t       new_ent;
  logic             is_full, is_empty;
  spq_ctrl_t        ctrl;
  logic [OCC_W-1:0] occ_q, occ_d;

  spq_entry_t cell_ent   [DEPTH];
  logic       cell_valid [DEPTH];
  logic       cell_keep  [DEPTH];

  logic                     out_valid_q;
  spq_status_e              status_q, status_d;
  logic signed [VAL_W-1:0]  rval_q, rval_d;
  logic signed [PRIO_W-1:0] rprio_q, rprio_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign op            = spq_op_e'(s_axis_tdata[0]);
  assign new_ent.value = s_axis_tdata[VAL_W:1];
  assign new_ent.prio  = s_axis_tdata[VAL_W+PRIO_W:VAL_W+1];

  assign is_full  = (occ_q == OCC_W'(DEPTH));
  assign is_empty = (occ_q == '0);

  always_comb begin
    ctrl.ins = 1'b0;
    ctrl.rem = 1'b0;
    ctrl.ent = new_ent;
    occ_d    = occ_q;
    status_d = ST_DONE;
    rval_d   = '0;
    rprio_d  = '0;
    if (in_fire) begin
      unique case (op)
        OP_INSERT: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.ins = 1'b1;
            occ_d    = occ_q + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.rem = 1'b1;
            occ_d    = occ_q - 1'b1;
            rval_d   = cell_ent[0].value;
            rprio_d  = cell_ent[0].prio;
          end
        end
        default: begin
          status_d = ST_DONE;
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t left_ent, right_ent;
    logic       left_valid, left_keep, right_valid;

    if (i == 0) begin : g_head
      assign left_ent   = new_ent;
      assign left_valid = 1'b1;
      assign left_keep  = 1'b1;
    end else begin : g_body
      assign left_ent   = cell_ent[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_keep  = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ent   = cell_ent[i];
      assign right_valid = 1'b0;
    end else begin : g_mid
      assign right_ent   = cell_ent[i+1];
      assign right_valid = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_ent_i    (left_ent),
      .left_valid_i  (left_valid),
      .left_keep_i   (left_keep),
      .right_ent_i   (right_ent),
      .right_valid_i (right_valid),
      .ent_o         (cell_ent[i]),
      .valid_o       (cell_valid[i]),
      .keep_o        (cell_keep[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      rval_q   <= rval_d;
      rprio_q  <= rprio_d;
    end
  end

  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cnt_q <= CNT_W'(occ_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - STAT_W - VAL_W - PRIO_W - CNT_W)'(0),
                          cnt_q, rprio_q, rval_q, status_q};

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps
// Testbench for sorted_priority_queue_core: streams insert and remove requests,
// tracks the expected queue contents in a sorted-array model and checks every
// result in order. Depends on spq_pkg and sorted_priority_queue_core.

module testbench;
  import spq_pkg::*;

  typedef struct {
    spq_status_e              status;
    logic signed [VAL_W-1:0]  value;
    logic signed [PRIO_W-1:0] prio;
    logic [CNT_W-1:0]         count;
  } pq_result_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  spq_entry_t  sorted_slots [SPQ_DEPTH];
  int unsigned slot_count = 0;
  pq_result_t  pending_results [$];

  bit tx_idle_en   = 1'b1;
  bit rx_idle_en   = 1'b1;
  bit rx_stall_req = 1'b0;
  int rx_stall_left = 0;
  int errors = 0, n_requests = 0, n_full = 0, n_empty = 0, n_removed = 0;

  sorted_priority_queue_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sorted-array model: highest priority in slot 0, ties in arrival order.
  function automatic pq_result_t pq_apply(spq_op_e op, logic signed [VAL_W-1:0] val,
                                          logic signed [PRIO_W-1:0] pri);
    pq_result_t  r;
    int unsigned pos;
    int unsigned i;
    r.status = ST_DONE;
    r.value  = '0;
    r.prio   = '0;
    if (op == OP_INSERT) begin
      if (slot_count >= SPQ_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = slot_count;
        while (pos > 0 && pri > $signed(sorted_slots[pos-1].prio)) begin
          sorted_slots[pos] = sorted_slots[pos-1];
          pos--;
        end
        sorted_slots[pos].value = val;
        sorted_slots[pos].prio  = pri;
        slot_count++;
      end
    end else if (slot_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.value = sorted_slots[0].value;
      r.prio  = sorted_slots[0].prio;
      for (i = 0; i + 1 < slot_count; i++) sorted_slots[i] = sorted_slots[i+1];
      slot_count--;
    end
    r.count = CNT_W'(slot_count);
    return r;
  endfunction

  function automatic logic [PRIO_W-1:0] pick_prio(int mode);
    case (mode)
      1: return PRIO_W'($urandom_range(3)) - PRIO_W'(2);   // narrow band, many ties
      2: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return PRIO_W'($urandom_range(65535));
    endcase
  endfunction

  // Valid stays high after acceptance; the next call replaces the request or
  // wait_all_results drops valid.
  task automatic send_request(spq_op_e op, logic signed [VAL_W-1:0] val,
                              logic signed [PRIO_W-1:0] pri);
    @(negedge clk_i);
    if (tx_idle_en && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, pri, val, op};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(pq_apply(op, val, pri));
    n_requests++;
  endtask

  task automatic send_random(int ins_pct, int prio_mode);
    if ($urandom_range(99) < ins_pct) send_request(OP_INSERT, $urandom, pick_prio(prio_mode));
    else send_request(OP_REMOVE, $urandom, PRIO_W'($urandom));
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_corners();
    send_request(OP_REMOVE, $urandom, PRIO_W'($urandom));
    send_request(OP_INSERT, 32'h0000_0001, 16'h0005);
    send_request(OP_INSERT, 32'h7FFF_FFFF, 16'h7FFF);
    send_request(OP_INSERT, 32'h0000_0002, 16'h0005);
    send_request(OP_INSERT, 32'h8000_0000, 16'h8000);
    send_request(OP_INSERT, 32'h0000_0000, 16'h0000);
    send_request(OP_INSERT, 32'h0000_0003, 16'h0005);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(OP_INSERT, 32'h1234_5678, 16'h7FFF);
    send_request(OP_INSERT, $urandom, 16'h7FFF);        // full: rejected
    repeat (SPQ_DEPTH + 1) send_request(OP_REMOVE, $urandom, PRIO_W'($urandom));
    wait_all_results();
  endtask

  // Receiver holds off while the sender keeps offering, so the input backs up.
  task automatic test_output_backpressure();
    tx_idle_en   = 1'b0;
    rx_stall_req = 1'b1;
    repeat (24) send_random(60, 0);
    tx_idle_en = 1'b1;
    wait_all_results();
  endtask

  task automatic test_random_mix(int n_items);
    int sent;
    int burst_len;
    int ins_pct;
    int prio_mode;
    sent = 0;
    while (sent < n_items) begin
      burst_len = $urandom_range(30, 8);
      case ($urandom_range(2))
        0: ins_pct = 75;
        1: ins_pct = 25;
        default: ins_pct = 50;
      endcase
      prio_mode = $urandom_range(3);
      repeat (burst_len) send_random(ins_pct, prio_mode);
      sent += burst_len;
      if ($urandom_range(7) == 0) wait_all_results();
    end
  endtask

  task automatic test_back_to_back(int n_items);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (n_items) send_random(50, $urandom_range(3));
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  always @(negedge clk_i) begin
    if (rx_stall_req) begin
      rx_stall_left = 64;
      rx_stall_req  = 1'b0;
    end
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(rx_idle_en && $urandom_range(99) < 15);
    end
  end

  always @(posedge clk_i) begin
    pq_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result, tdata %h", m_axis_tdata);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        case (exp_r.status)
          ST_FULL:  n_full++;
          ST_EMPTY: n_empty++;
          default:  ;
        endcase
        if (m_axis_tdata[1:0] !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, m_axis_tdata[1:0]);
          errors++;
        end
        if ($signed(m_axis_tdata[33:2]) !== exp_r.value) begin
          $error("removed_value: expected %0d, got %0d", exp_r.value,
                 $signed(m_axis_tdata[33:2]));
          errors++;
        end
        if ($signed(m_axis_tdata[49:34]) !== exp_r.prio) begin
          $error("removed_priority: expected %0d, got %0d", exp_r.prio,
                 $signed(m_axis_tdata[49:34]));
          errors++;
        end
        if (m_axis_tdata[53:50] !== exp_r.count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.count, m_axis_tdata[53:50]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready && s_axis_tdata[0] == OP_REMOVE)
      n_removed++;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_corners();
    test_output_backpressure();
    test_random_mix(700);
    test_back_to_back(250);
    test_random_mix(120);
    wait_all_results();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d requests (%0d remove requests) with random gaps and output stalls;",
             n_requests, n_removed);
    $display("seen %0d inserts into a full queue and %0d removes on an empty one.",
             n_full, n_empty);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout: %0d results still outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
